### hdl/tbk_pkg.sv
// Package for the timer bank: bank size, command and status codes, item types.
// No dependencies; every other file of the block imports it.
`timescale 1ns / 1ps

package tbk_pkg;

    localparam int NUM_TIMERS = 8;
    localparam int IDX_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TIMERS - 1);
    localparam logic [7:0] BANK_SIZE = 8'(NUM_TIMERS);

    localparam logic [3:0] MODE_ALLOC      = 4'd0;
    localparam logic [3:0] MODE_FREE       = 4'd1;
    localparam logic [3:0] MODE_SET        = 4'd2;
    localparam logic [3:0] MODE_RESTART    = 4'd3;
    localparam logic [3:0] MODE_CANCEL     = 4'd4;
    localparam logic [3:0] MODE_CANCEL_ALL = 4'd5;
    localparam logic [3:0] MODE_QUERY      = 4'd6;
    localparam logic [3:0] MODE_TICK       = 4'd7;
    localparam logic [3:0] MODE_NEXT_DUE   = 4'd8;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_NO_FREE = 2'd1;
    localparam logic [1:0] STATUS_BAD_H   = 2'd2;

    typedef struct packed {
        logic [3:0]  mode;
        logic [7:0]  handle;
        logic        repeat_req;
        logic [31:0] duration_seconds;
        logic [31:0] now_seconds;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  slot;
        logic        is_running;
        logic        expired;
        logic [31:0] next_due_seconds;
        logic        alarm_valid;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
    } t_alu_op;

    typedef struct packed {
        logic [31:0] diff;
        logic        borrow;
        logic        zero;
    } t_alu_res;

endpackage

### hdl/tbk_alu.sv
// Shared subtract unit of the timer bank: a - b with borrow and zero flags, registered.
// Depends on tbk_pkg for the operand and result structs.
`timescale 1ns / 1ps

module tbk_alu import tbk_pkg::*; (
    input  logic     i_clk,
    input  t_alu_op  i_op,
    output t_alu_res o_res
);

    logic [32:0] n_sub;
    t_alu_res    r_res;

    assign n_sub = {1'b0, i_op.a} - {1'b0, i_op.b};
    assign o_res = r_res;

    always_ff @(posedge i_clk) begin
        r_res.diff   <= n_sub[31:0];
        r_res.borrow <= n_sub[32];
        r_res.zero   <= (n_sub[31:0] == 32'd0);
    end

endmodule

### hdl/tbk_seq.sv
// Command sequencer and timer state of the timer bank.
// Depends on tbk_pkg; drives the shared subtract unit and hands result items to the top.
`timescale 1ns / 1ps

module tbk_seq import tbk_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_item  i_in_item,
    output logic      o_in_stall,
    output t_alu_op   o_alu_op,
    input  t_alu_res  i_alu_res,
    input  logic      i_res_ready,
    output logic      o_res_load,
    output t_out_item o_res
);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_EXEC = 8'b0000_0010,
        S_EL   = 8'b0000_0100,
        S_REM  = 8'b0000_1000,
        S_CHK  = 8'b0001_0000,
        S_MIN  = 8'b0010_0000,
        S_EMIT = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } t_state;

    t_state                r_state, n_state;
    t_in_item              r_cmd, n_cmd;
    logic [IDX_W-1:0]      r_idx, n_idx;
    logic [31:0]           r_best, n_best;
    logic                  r_any, n_any;
    logic [31:0]           r_rem, n_rem;
    t_out_item             r_final, n_final;
    logic [NUM_TIMERS-1:0] r_alloc, n_alloc;
    logic [NUM_TIMERS-1:0] r_active, n_active;
    logic [NUM_TIMERS-1:0] r_periodic, n_periodic;
    logic [31:0]           r_start  [NUM_TIMERS];
    logic [31:0]           n_start  [NUM_TIMERS];
    logic [31:0]           r_period [NUM_TIMERS];
    logic [31:0]           n_period [NUM_TIMERS];

    logic [IDX_W-1:0] h_idx;
    logic             h_in;
    logic             h_ok;
    logic             free_found;
    logic [IDX_W-1:0] free_idx;
    logic             is_tick;
    logic             due;
    logic             adv;

    assign o_in_stall = (r_state != S_IDLE);
    assign h_idx      = r_cmd.handle[IDX_W-1:0];
    assign h_in       = (r_cmd.handle < BANK_SIZE);
    assign h_ok       = h_in && r_alloc[h_idx];
    assign is_tick    = (r_cmd.mode == MODE_TICK);
    // Elapsed time has reached the period when period - elapsed is zero or negative.
    assign due        = i_alu_res.borrow || i_alu_res.zero;

    // Lowest free slot.
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
            if (!r_alloc[i]) begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_idx      = r_idx;
        n_best     = r_best;
        n_any      = r_any;
        n_rem      = r_rem;
        n_final    = r_final;
        n_alloc    = r_alloc;
        n_active   = r_active;
        n_periodic = r_periodic;
        n_start    = r_start;
        n_period   = r_period;
        o_alu_op   = '0;
        o_res_load = 1'b0;
        o_res      = '0;
        adv        = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd   = i_in_item;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_idx        = '0;
                n_best       = '1;
                n_any        = 1'b0;
                n_final      = '0;
                n_final.last = 1'b1;
                n_state      = S_DONE;
                case (r_cmd.mode)
                    MODE_ALLOC: begin
                        if (free_found) begin
                            n_alloc[free_idx]  = 1'b1;
                            n_active[free_idx] = 1'b0;
                            n_final.slot       = 8'(free_idx);
                        end else begin
                            n_final.status = STATUS_NO_FREE;
                        end
                    end
                    MODE_FREE: begin
                        if (!h_in) begin
                            n_final.status = STATUS_BAD_H;
                        end else begin
                            n_alloc[h_idx]  = 1'b0;
                            n_active[h_idx] = 1'b0;
                        end
                    end
                    MODE_SET, MODE_RESTART, MODE_CANCEL, MODE_QUERY: begin
                        if (!h_ok) begin
                            n_final.status = STATUS_BAD_H;
                        end else if (r_cmd.mode == MODE_SET) begin
                            n_periodic[h_idx] = r_cmd.repeat_req;
                            n_start[h_idx]    = r_cmd.now_seconds;
                            n_period[h_idx]   = (r_cmd.duration_seconds == 32'd0) ?
                                                32'd1 : r_cmd.duration_seconds;
                            n_active[h_idx]   = 1'b1;
                        end else if (r_cmd.mode == MODE_RESTART) begin
                            n_start[h_idx] = r_cmd.now_seconds;
                        end else if (r_cmd.mode == MODE_CANCEL) begin
                            n_active[h_idx] = 1'b0;
                        end else begin
                            n_final.is_running = r_active[h_idx];
                        end
                    end
                    MODE_CANCEL_ALL: begin
                        n_active = r_active & ~r_alloc;
                    end
                    MODE_TICK, MODE_NEXT_DUE: begin
                        n_state = S_EL;
                    end
                    default: begin
                    end
                endcase
            end
            S_EL: begin
                o_alu_op.a = r_cmd.now_seconds;
                o_alu_op.b = r_start[r_idx];
                if (r_active[r_idx]) begin
                    n_state = S_REM;
                end else begin
                    adv = 1'b1;
                end
            end
            S_REM: begin
                // The unit now holds the elapsed time.
                o_alu_op.a = r_period[r_idx];
                o_alu_op.b = i_alu_res.diff;
                n_state    = S_CHK;
            end
            S_CHK: begin
                if (is_tick) begin
                    if (due) begin
                        if (r_periodic[r_idx]) begin
                            n_start[r_idx] = r_cmd.now_seconds;
                        end else begin
                            n_active[r_idx] = 1'b0;
                        end
                        n_state = S_EMIT;
                    end else begin
                        adv = 1'b1;
                    end
                end else begin
                    n_any = 1'b1;
                    if (due) begin
                        n_best = '0;
                        adv    = 1'b1;
                    end else begin
                        // Compare the remaining time against the running minimum.
                        o_alu_op.a = i_alu_res.diff;
                        o_alu_op.b = r_best;
                        n_rem      = i_alu_res.diff;
                        n_state    = S_MIN;
                    end
                end
            end
            S_MIN: begin
                if (i_alu_res.borrow) begin
                    n_best = r_rem;
                end
                adv = 1'b1;
            end
            S_EMIT: begin
                o_res.status  = STATUS_OK;
                o_res.slot    = 8'(r_idx);
                o_res.expired = 1'b1;
                if (i_res_ready) begin
                    o_res_load = 1'b1;
                    adv        = 1'b1;
                end
            end
            S_DONE: begin
                o_res = r_final;
                if (i_res_ready) begin
                    o_res_load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Step to the next slot, or close the scan with its final item.
        if (adv) begin
            if (r_idx == LAST_IDX) begin
                n_final      = '0;
                n_final.last = 1'b1;
                if (!is_tick) begin
                    n_final.next_due_seconds = n_best;
                    n_final.alarm_valid      = n_any;
                end
                n_state = S_DONE;
            end else begin
                n_idx   = r_idx + IDX_W'(1);
                n_state = S_EL;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_alloc    <= '0;
            r_active   <= '0;
            r_periodic <= '0;
        end else begin
            r_state    <= n_state;
            r_alloc    <= n_alloc;
            r_active   <= n_active;
            r_periodic <= n_periodic;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_idx    <= n_idx;
        r_best   <= n_best;
        r_any    <= n_any;
        r_rem    <= n_rem;
        r_final  <= n_final;
        r_start  <= n_start;
        r_period <= n_period;
    end

endmodule

### hdl/timer_bank_one_shot_periodic_top.sv
// Channel   Direction  Handshake                     Payload
// input     in         i_in_valid / o_in_stall       i_in_item  (t_in_item)
// result    out        o_out_valid / i_out_stall     o_out_item (t_out_item)
//
// One command at a time. A single-result command passes S_EXEC and S_DONE before its
// item is in the output register, and the next item is taken once S_IDLE is back.
// Tick and next-due scan the slots through the shared subtract unit: an idle slot is
// skipped in S_EL, a running slot passes S_EL, S_REM and S_CHK (plus S_EMIT per expiry
// item on tick), and on next-due also S_MIN while it is not yet due.
// Reset is synchronous, active low, and clears the slot flags. A stalled output
// holds the sequencer when it has an item to hand over.
// Depends on tbk_pkg, tbk_alu and tbk_seq.
`timescale 1ns / 1ps

module timer_bank_one_shot_periodic_top import tbk_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_item  i_in_item,
    output logic      o_in_stall,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    t_alu_op   alu_op;
    t_alu_res  alu_res;
    logic      res_ready;
    logic      res_load;
    t_out_item res_item;

    logic      r_out_valid, n_out_valid;
    t_out_item r_out_item, n_out_item;

    assign res_ready   = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    tbk_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_item   (i_in_item),
        .o_in_stall  (o_in_stall),
        .o_alu_op    (alu_op),
        .i_alu_res   (alu_res),
        .i_res_ready (res_ready),
        .o_res_load  (res_load),
        .o_res       (res_item)
    );

    tbk_alu u_alu (
        .i_clk (i_clk),
        .i_op  (alu_op),
        .o_res (alu_res)
    );

    always_comb begin
        n_out_valid = r_out_valid;
        n_out_item  = r_out_item;
        if (res_load) begin
            n_out_valid = 1'b1;
            n_out_item  = res_item;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_item <= n_out_item;
    end

endmodule

### hdl/tbk_checker.sv
// Port-level checks for the timer bank, attached to the top level by bind.
// Depends on tbk_pkg for the result item type.
`timescale 1ns / 1ps

module tbk_checker import tbk_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_item
);

    // A stalled result item stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result item dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_item))
        else $error("stalled result item changed");

    // The bank works on one command at a time.
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second item accepted during a command");

    // An expiry item is never the closing item of a tick.
    a_exp_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.expired |-> !o_out_item.last &&
        (o_out_item.status == STATUS_OK))
        else $error("expiry item marked last or not ok");

endmodule

bind timer_bank_one_shot_periodic_top tbk_checker u_chk (.*);
